// File: rtl/mpd_pkg.sv
package mpd_pkg;

   // Status bit that flags auxiliary (mouse) data
   localparam int AUX_BIT = 5;

   // Bytes in one mouse packet
   localparam int PACKET_LEN = 3;

   // Buttons carried in packet byte 0
   localparam int NUM_BUTTONS = 3;

   // Default depth of the packet queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Register map
   localparam logic REG_EVENTS_ENABLED = 1'b0;
   localparam int   CSR_ADDR_W         = 3;

   // Port widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Event kinds on the result channel
   typedef enum logic [1:0] {
      EV_MOVE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   // One completed packet, as classified by the front end
   typedef struct packed {
      logic                   move;
      logic [7:0]             dx;
      logic [7:0]             dy;
      logic [NUM_BUTTONS-1:0] changed;
      logic [NUM_BUTTONS-1:0] held;
   } packet_desc_type;

endpackage

// File: rtl/mpd_front.sv
module mpd_front
   import mpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  events_enabled,
   input  logic                  req_take,
   input  logic [7:0]            ctrl_status,
   input  logic [7:0]            data_byte,
   output logic                  push,
   output packet_desc_type       push_desc
);

   logic [1:0]             byte_position_ff, byte_position_in;
   logic [NUM_BUTTONS-1:0] button_state_ff, button_state_in;
   logic [7:0]             packet_store_ff [0:1];
   logic [1:0]             pos_eff;
   logic                   taken;
   logic                   last_pos;
   logic [7:0]             btn_byte;

   // Clamp the unreachable position to the last byte
   assign pos_eff  = (byte_position_ff == 2'd3) ? 2'(PACKET_LEN - 1) : byte_position_ff;
   assign taken    = req_take && ctrl_status[AUX_BIT];
   assign last_pos = (pos_eff == 2'(PACKET_LEN - 1));
   assign btn_byte = packet_store_ff[0];

   // Classify a completed packet
   always_comb begin
      push_desc.dx      = packet_store_ff[1];
      push_desc.dy      = data_byte;
      push_desc.move    = (packet_store_ff[1] != 8'd0) || (data_byte != 8'd0);
      push_desc.changed = btn_byte[NUM_BUTTONS-1:0] ^ button_state_ff;
      push_desc.held    = button_state_ff;
      push = taken && events_enabled && last_pos
             && (push_desc.move || (push_desc.changed != '0));
   end

   // Advance position and buttons
   always_comb begin
      byte_position_in = byte_position_ff;
      button_state_in  = button_state_ff;
      if (taken && events_enabled) begin
         if (last_pos) begin
            byte_position_in = 2'd0;
            button_state_in  = btn_byte[NUM_BUTTONS-1:0];
         end else begin
            byte_position_in = pos_eff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= 2'd0;
         button_state_ff  <= '0;
      end else begin
         byte_position_ff <= byte_position_in;
         button_state_ff  <= button_state_in;
      end
   end

   // Store the first two packet bytes; the last one is used as it arrives
   always_ff @(posedge clock) begin
      if (taken && !pos_eff[1]) begin
         packet_store_ff[pos_eff[0]] <= data_byte;
      end
   end

endmodule

// File: rtl/mpd_queue.sv
module mpd_queue
   import mpd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  packet_desc_type push_desc,
   output logic            full,
   input  logic            pop,
   output packet_desc_type pop_desc,
   output logic            empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   packet_desc_type  mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_desc = mem_ff[rd_ptr_ff];

   // Step pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: rtl/mpd_back.sv
module mpd_back
   import mpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  packet_desc_type       q_desc,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   // Pending events: bit 0 move, bits 1..3 buttons 1..3
   logic [NUM_BUTTONS:0]   pending_ff, pending_in;
   logic [NUM_BUTTONS:0]   pick, pending_left;
   logic [7:0]             dx_ff, dy_ff;
   logic [NUM_BUTTONS-1:0] held_ff;
   logic                   work_valid, advance, emit;

   logic                   out_valid_ff, out_valid_in;
   event_kind_type         out_kind_ff, out_kind_in;
   logic [7:0]             out_x_ff, out_x_in;
   logic [8:0]             out_y_ff, out_y_in;
   logic [1:0]             out_btn_ff, out_btn_in;
   logic                   out_last_ff, out_last_in;

   assign work_valid   = (pending_ff != '0);
   assign advance      = !out_valid_ff || rsp_tready;
   assign emit         = work_valid && advance;
   // Lowest pending event goes first
   assign pick         = pending_ff & (~pending_ff + 1'b1);
   assign pending_left = pending_ff & ~pick;
   assign q_pop        = !q_empty && (!work_valid || (emit && (pending_left == '0)));

   // Build the next event
   always_comb begin
      out_kind_in = EV_MOVE;
      out_x_in    = 8'd0;
      out_y_in    = 9'd0;
      out_btn_in  = 2'd0;
      out_last_in = (pending_left == '0);
      if (pick[0]) begin
         out_x_in = dx_ff;
         out_y_in = 9'd0 - {1'b0, dy_ff};
      end else begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (pick[i+1]) begin
               out_kind_in = held_ff[i] ? EV_RELEASE : EV_PRESS;
               out_btn_in  = 2'(i + 1);
            end
         end
      end
   end

   // Work register: drop served events, load the next packet
   always_comb begin
      pending_in = pending_ff;
      if (emit) begin
         pending_in = pending_left;
      end
      if (q_pop) begin
         pending_in = {q_desc.changed, q_desc.move};
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = work_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         dx_ff   <= q_desc.dx;
         dy_ff   <= q_desc.dy;
         held_ff <= q_desc.held;
      end
      if (emit) begin
         out_kind_ff <= out_kind_in;
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_btn_ff  <= out_btn_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_btn_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: rtl/mouse_packet_event_decoder_core.sv
// A completed packet passes the packet queue, the work register and the output register.
// Throughput: one request per cycle while the queue is not full; a packet gives one event
// per cycle while rsp is ready, up to four, set by the back end sequencer's single output register.
// Reset (synchronous, active high): position and buttons cleared, events enabled,
// packet queue and output emptied; stored packet bytes are not cleared.
module mouse_packet_event_decoder_core
   import mpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   // request: [7:0] ctrl_status, [15:8] data_byte
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response: [7:0] move_x, [16:8] move_y, [18:17] button_number, rest zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // response: [1:0] event_kind
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic            events_enabled_ff, events_enabled_in;
   logic            csr_write;
   logic            req_take;
   logic            push, q_full, q_pop, q_empty;
   packet_desc_type push_desc, pop_desc;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_EVENTS_ENABLED) ? {31'd0, events_enabled_ff}
                                                             : 32'd0;

   always_comb begin
      events_enabled_in = events_enabled_ff;
      if (csr_write && (csr_paddr[2] == REG_EVENTS_ENABLED)) begin
         events_enabled_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         events_enabled_ff <= 1'b1;
      end else begin
         events_enabled_ff <= events_enabled_in;
      end
   end

   // Hold requests while the queue is full
   assign req_tready = !q_full;
   assign req_take   = req_tvalid && req_tready;

   mpd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .events_enabled (events_enabled_ff),
      .req_take       (req_take),
      .ctrl_status    (req_tdata[7:0]),
      .data_byte      (req_tdata[15:8]),
      .push           (push),
      .push_desc      (push_desc)
   );

   mpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (pop_desc),
      .empty     (q_empty)
   );

   mpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_desc     (pop_desc),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
